>>> hdl/sit_pkg.sv
// shared types and constants for the sorted insertion table
`default_nettype none

package sit_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    localparam int S_FIELDS_W = MODE_W + KEY_W + INDEX_W;
    localparam int M_FIELDS_W = KEY_W + COUNT_W + STAT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

endpackage

`default_nettype wire

>>> hdl/sorted_insertion_table.sv
// sorted insertion table: ordered key table with insert, lookup and remove
//
// Each input transfer runs one operation on a table of DEPTH 32-bit keys kept in
// ascending order, and produces exactly one result transfer. The table sits in a
// memory with one write port and one read port, the read registered, and one
// entry moves per cycle. An insert walks down from the top, moving each entry
// not below the new key up one place; a lookup reads one entry; a remove at
// index i walks up, moving later entries down. Full-table and out-of-range
// requests finish with no table walk. The table-walk is bound by the one memory
// read per cycle. s_tready is high only while the sequencer is idle; a finished
// result waits in the output register and the next item can be taken while it
// does. Reset clears the count; no clearing pass.
`default_nettype none

module sorted_insertion_table (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // mode [1:0], key [33:2], index [37:34], zero fill above
    input  wire logic [sit_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // value [31:0], count [36:32], status [38:37], zero fill above
    output logic      [sit_pkg::M_TDATA_W-1:0]  m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_LK_RD,
        S_RM_VAL,
        S_RM_SH,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [sit_pkg::CNT_W-1:0]     n_reg, n_next;
    logic [sit_pkg::CNT_W-1:0]     q_reg, q_next;
    logic [sit_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [sit_pkg::KEY_W-1:0]     val_reg, val_next;
    sit_pkg::status_t              stat_reg, stat_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [sit_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [sit_pkg::KEY_W-1:0]     tbl_mem [sit_pkg::DEPTH];
    logic [sit_pkg::KEY_W-1:0]     rdata_reg;
    logic                          mem_we;
    logic [sit_pkg::IDX_W-1:0]     mem_waddr;
    logic [sit_pkg::IDX_W-1:0]     mem_raddr;
    logic [sit_pkg::KEY_W-1:0]     mem_wdata;

    sit_pkg::mode_t                in_mode;
    logic [sit_pkg::KEY_W-1:0]     in_key;
    logic [sit_pkg::CNT_W-1:0]     in_idx;
    logic [sit_pkg::CNT_W-1:0]     q_p1;
    logic [sit_pkg::CNT_W-1:0]     q_p2;
    logic [sit_pkg::CNT_W-1:0]     q_m1;
    logic [sit_pkg::CNT_W-1:0]     q_m2;
    logic                          out_free;

    function automatic logic [sit_pkg::IDX_W-1:0] q_m1_of(input logic [sit_pkg::CNT_W-1:0] v);
        logic [sit_pkg::CNT_W-1:0] d;
        d = v - sit_pkg::CNT_W'(1);
        return d[sit_pkg::IDX_W-1:0];
    endfunction

    assign in_mode = sit_pkg::mode_t'(s_tdata[sit_pkg::MODE_W-1:0]);
    assign in_key  = s_tdata[sit_pkg::MODE_W +: sit_pkg::KEY_W];
    assign in_idx  = sit_pkg::CNT_W'(
        s_tdata[sit_pkg::MODE_W + sit_pkg::KEY_W +: sit_pkg::INDEX_W]);

    assign q_p1     = q_reg + sit_pkg::CNT_W'(1);
    assign q_p2     = q_reg + sit_pkg::CNT_W'(2);
    assign q_m1     = q_reg - sit_pkg::CNT_W'(1);
    assign q_m2     = q_reg - sit_pkg::CNT_W'(2);
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tbl_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= tbl_mem[mem_raddr];
    end

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        q_next        = q_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        stat_next     = stat_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = q_reg[sit_pkg::IDX_W-1:0];
        mem_wdata     = key_reg;
        mem_raddr     = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    key_next  = in_key;
                    val_next  = '0;
                    stat_next = sit_pkg::STAT_OK;
                    state_next = S_DONE;
                    case (in_mode)
                        sit_pkg::MODE_INSERT: begin
                            q_next = n_reg;
                            if (n_reg == sit_pkg::CNT_W'(sit_pkg::DEPTH)) begin
                                stat_next = sit_pkg::STAT_FULL;
                            end else if (n_reg == '0) begin
                                state_next = S_INS_PUT;
                            end else begin
                                mem_raddr  = q_m1_of(n_reg);
                                state_next = S_INS_CMP;
                            end
                        end
                        sit_pkg::MODE_LOOKUP: begin
                            if (in_idx >= n_reg) begin
                                stat_next = sit_pkg::STAT_RANGE;
                            end else begin
                                mem_raddr  = in_idx[sit_pkg::IDX_W-1:0];
                                state_next = S_LK_RD;
                            end
                        end
                        sit_pkg::MODE_REMOVE: begin
                            q_next = in_idx;
                            if (in_idx >= n_reg) begin
                                stat_next = sit_pkg::STAT_RANGE;
                            end else begin
                                mem_raddr  = in_idx[sit_pkg::IDX_W-1:0];
                                state_next = S_RM_VAL;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // rdata_reg holds the entry just below slot q
            S_INS_CMP: begin
                mem_we = 1'b1;
                if (rdata_reg >= key_reg) begin
                    mem_wdata = rdata_reg;
                    q_next    = q_m1;
                    if (q_reg == sit_pkg::CNT_W'(1)) begin
                        state_next = S_INS_PUT;
                    end else begin
                        mem_raddr = q_m2[sit_pkg::IDX_W-1:0];
                    end
                end else begin
                    mem_wdata  = key_reg;
                    n_next     = n_reg + sit_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_INS_PUT: begin
                mem_we     = 1'b1;
                mem_wdata  = key_reg;
                n_next     = n_reg + sit_pkg::CNT_W'(1);
                state_next = S_DONE;
            end
            S_LK_RD: begin
                val_next   = rdata_reg;
                state_next = S_DONE;
            end
            S_RM_VAL: begin
                val_next = rdata_reg;
                if (q_p1 < n_reg) begin
                    mem_raddr  = q_p1[sit_pkg::IDX_W-1:0];
                    state_next = S_RM_SH;
                end else begin
                    n_next     = n_reg - sit_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            // rdata_reg holds the entry just above slot q
            S_RM_SH: begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
                q_next    = q_p1;
                if (q_p2 < n_reg) begin
                    mem_raddr = q_p2[sit_pkg::IDX_W-1:0];
                end else begin
                    n_next     = n_reg - sit_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = sit_pkg::M_TDATA_W'({stat_reg,
                                                         sit_pkg::COUNT_W'(n_reg),
                                                         val_reg});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            n_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        q_reg       <= q_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        stat_reg    <= stat_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= sit_pkg::CNT_W'(sit_pkg::DEPTH))
        else $error("entry count above table depth");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[sit_pkg::KEY_W + sit_pkg::COUNT_W +: sit_pkg::STAT_W]
            == sit_pkg::STAT_FULL)
        |-> m_tdata[sit_pkg::KEY_W +: sit_pkg::COUNT_W]
            == sit_pkg::COUNT_W'(sit_pkg::DEPTH))
        else $error("full status reported with room in the table");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[sit_pkg::KEY_W + sit_pkg::COUNT_W +: sit_pkg::STAT_W]
            == sit_pkg::STAT_RANGE)
        |-> m_tdata[sit_pkg::KEY_W-1:0] == '0)
        else $error("out of range result carries a value");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer idle right after an input transfer");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) && (state_next == S_IDLE) |=> $stable(n_reg))
        else $error("count changed while handing off a result");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
// testbench for the sorted insertion table: directed and random operations with a mirror table
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // mode 3 is not a defined operation and must leave the table alone
    localparam logic [sit_pkg::MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int RANDOM_ITEMS = 1080;
    localparam int QUIET_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [sit_pkg::KEY_W-1:0]   value;
        logic [sit_pkg::COUNT_W-1:0] count;
        logic [sit_pkg::STAT_W-1:0]  status;
    } table_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [sit_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [sit_pkg::M_TDATA_W-1:0] m_tdata;

    // mirror of the table contents
    logic [sit_pkg::KEY_W-1:0] mirror_keys [sit_pkg::DEPTH];
    int                        mirror_count;
    table_result_t             pending_results [$];

    int  mismatch_count;
    int  cycle_count;
    bit  send_gaps;
    bit  recv_stalls;

    sorted_insertion_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // applies one operation to the mirror and queues the result it must produce
    function automatic void predict_table_op(input logic [sit_pkg::MODE_W-1:0] mode,
                                             input logic [sit_pkg::KEY_W-1:0] key,
                                             input logic [sit_pkg::INDEX_W-1:0] index);
        table_result_t r;
        int            p;
        int            q;
        r = '0;
        r.status = sit_pkg::STAT_OK;
        case (mode)
            sit_pkg::MODE_INSERT: begin
                if (mirror_count >= sit_pkg::DEPTH) begin
                    r.status = sit_pkg::STAT_FULL;
                end else begin
                    p = 0;
                    while (p < mirror_count && mirror_keys[p] < key)
                        p++;
                    for (q = mirror_count; q > p; q--)
                        mirror_keys[q] = mirror_keys[q-1];
                    mirror_keys[p] = key;
                    mirror_count++;
                end
            end
            sit_pkg::MODE_LOOKUP: begin
                if (int'(index) >= mirror_count)
                    r.status = sit_pkg::STAT_RANGE;
                else
                    r.value = mirror_keys[index];
            end
            sit_pkg::MODE_REMOVE: begin
                if (int'(index) >= mirror_count) begin
                    r.status = sit_pkg::STAT_RANGE;
                end else begin
                    r.value = mirror_keys[index];
                    for (q = int'(index); q + 1 < mirror_count; q++)
                        mirror_keys[q] = mirror_keys[q+1];
                    mirror_count--;
                end
            end
            default: ;
        endcase
        r.count = sit_pkg::COUNT_W'(mirror_count);
        pending_results.push_back(r);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic [sit_pkg::MODE_W-1:0] mode,
                             input logic [sit_pkg::KEY_W-1:0] key,
                             input logic [sit_pkg::INDEX_W-1:0] index);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tdata  = sit_pkg::S_TDATA_W'({index, key, mode});
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_table_op(mode, key, index);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        table_result_t got;
        table_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.value  = m_tdata[31:0];
            got.count  = m_tdata[36:32];
            got.status = m_tdata[38:37];
            if (pending_results.size() == 0) begin
                $display("%0t: expected no result, actual value %h count %0d status %0d",
                         $time, got.value, got.count, got.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value) begin
                    $display("%0t: value expected %h actual %h", $time, want.value, got.value);
                    mismatch_count++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
                    mismatch_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    mismatch_count++;
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (recv_stalls && $urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge aclk);
                @(negedge aclk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(0, 11)) @(negedge aclk);
        end
    end

    task automatic test_empty_table();
        send_item(sit_pkg::MODE_LOOKUP, 32'h0, 4'd0);
        send_item(sit_pkg::MODE_REMOVE, 32'hffff_ffff, 4'd15);
        send_item(MODE_NOP, 32'hdead_beef, 4'd7);
    endtask

    task automatic test_insert_order();
        send_item(sit_pkg::MODE_INSERT, 32'hffff_ffff, 4'd0);
        send_item(sit_pkg::MODE_INSERT, 32'h0000_0000, 4'd15);
        send_item(sit_pkg::MODE_INSERT, 32'h8000_0000, 4'd0);
        // equal key lands in front of the stored one
        send_item(sit_pkg::MODE_INSERT, 32'h8000_0000, 4'd0);
        send_item(sit_pkg::MODE_INSERT, 32'h0000_0001, 4'd0);
        send_item(sit_pkg::MODE_LOOKUP, 32'h0, 4'd0);
        send_item(sit_pkg::MODE_LOOKUP, 32'h0, 4'd4);
    endtask

    task automatic test_lookup_remove();
        send_item(sit_pkg::MODE_REMOVE, 32'h0, 4'd4);
        send_item(sit_pkg::MODE_REMOVE, 32'h0, 4'd0);
        send_item(sit_pkg::MODE_LOOKUP, 32'h0, 4'd3);
        send_item(sit_pkg::MODE_REMOVE, 32'h0, 4'd1);
        send_item(MODE_NOP, 32'h0, 4'd0);
    endtask

    task automatic test_full_table();
        int i;
        wait_drained();
        for (i = mirror_count; i < sit_pkg::DEPTH; i++)
            send_item(sit_pkg::MODE_INSERT, $urandom(), 4'd0);
        send_item(sit_pkg::MODE_INSERT, 32'h0, 4'd0);
        send_item(sit_pkg::MODE_LOOKUP, 32'h0, 4'd15);
        send_item(sit_pkg::MODE_REMOVE, 32'h0, 4'd15);
    endtask

    function automatic logic [sit_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;
            2, 3:    return sit_pkg::KEY_W'($urandom_range(0, 7));
            4:       return (mirror_count > 0) ?
                            mirror_keys[$urandom_range(0, mirror_count - 1)] : $urandom();
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [sit_pkg::INDEX_W-1:0] pick_index();
        if (mirror_count > 0 && $urandom_range(0, 9) < 8)
            return sit_pkg::INDEX_W'($urandom_range(0, mirror_count - 1));
        return sit_pkg::INDEX_W'($urandom_range(0, 15));
    endfunction

    // random operations in phases that lean toward filling or emptying the table
    task automatic test_random(input int n_items);
        int                         i;
        int                         phase_left;
        int                         ins_share;
        int                         r;
        bit                         filling;
        logic [sit_pkg::MODE_W-1:0] mode;
        filling    = 1'b1;
        phase_left = 0;
        for (i = 0; i < n_items; i++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(40, 120);
            end
            phase_left--;
            if (i == n_items - QUIET_ITEMS) begin
                send_gaps   = 1'b0;
                recv_stalls = 1'b0;
            end
            ins_share = filling ? 70 : 25;
            r = $urandom_range(0, 99);
            if (r < 2)
                mode = MODE_NOP;
            else if (r < 2 + ins_share)
                mode = sit_pkg::MODE_INSERT;
            else if (r < 2 + ins_share + (98 - ins_share) / 2)
                mode = sit_pkg::MODE_LOOKUP;
            else
                mode = sit_pkg::MODE_REMOVE;
            send_item(mode, pick_key(), pick_index());
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        mirror_count   = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_gaps      = 1'b1;
        recv_stalls    = 1'b1;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_empty_table();
        test_insert_order();
        test_lookup_remove();
        test_full_table();
        wait_drained();
        test_random(RANDOM_ITEMS);

        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
